// ----- hw/rtl/gwm_pkg.sv -----
// Shared types and constants for the glob wildcard matcher.
// Holds the opcode and state encodings and the pattern metacharacters.
// No dependencies.
package gwm_pkg;

   localparam int DefaultPatternLen = 64;

   typedef enum logic [1:0] {
      OP_CLEAR   = 2'd0,
      OP_APPEND  = 2'd1,
      OP_SUBJECT = 2'd2,
      OP_END     = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PRIME,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      CLS_OFF,
      CLS_FIRST,
      CLS_ITEM,
      CLS_DASH,
      CLS_HI
   } class_state_type;

   localparam logic [7:0] ChStar   = 8'h2A;
   localparam logic [7:0] ChQuery  = 8'h3F;
   localparam logic [7:0] ChLBrack = 8'h5B;
   localparam logic [7:0] ChRBrack = 8'h5D;
   localparam logic [7:0] ChBang   = 8'h21;
   localparam logic [7:0] ChCaret  = 8'h5E;
   localparam logic [7:0] ChDash   = 8'h2D;

endpackage

// ----- hw/rtl/gwm_if.sv -----
// Valid/ready channel interfaces for the glob wildcard matcher.
// The request channel carries opcode and data; the response channel the verdict.
// Depends on gwm_pkg.
interface gwm_req_if;
   import gwm_pkg::*;
   logic       valid;
   logic       ready;
   opcode_type opcode;
   logic [7:0] data_byte;

   modport source (output valid, output opcode, output data_byte, input ready);
   modport sink (input valid, input opcode, input data_byte, output ready);
endinterface

interface gwm_rsp_if;
   logic valid;
   logic ready;
   logic matched;
   logic pattern_overflow;

   modport source (output valid, output matched, output pattern_overflow, input ready);
   modport sink (input valid, input matched, input pattern_overflow, output ready);
endinterface

// ----- hw/rtl/glob_wildcard_matcher.sv -----
// Glob pattern matcher top level: pattern store, active-position scan, class parser.
// Depends on gwm_pkg and the channel interfaces in gwm_if.sv.
//
//   channel | dir | payload                      | word
//   req     | in  | opcode, data_byte            | one pattern or subject command
//   rsp     | out | matched, pattern_overflow    | one verdict per end of subject
//
// Clear and append are taken in the idle state, the only state that accepts a request.
// A subject byte goes from its accept through the prime state, which primes the pattern
// memory read port, to the scan state, in which the single port walks the PATTERN_LEN + 1
// positions. An end of subject adds the emit state, which loads the verdict register.
// Reset is synchronous and clears the pattern length, the flags and the active set.
// A pending verdict sits in the output register; the emit cycle stalls only while it waits.
module glob_wildcard_matcher #(
   parameter int PATTERN_LEN = gwm_pkg::DefaultPatternLen
) (
   input logic     clock,
   input logic     reset,
   gwm_req_if.sink   req,
   gwm_rsp_if.source rsp
);
   import gwm_pkg::*;

   localparam int LW = $clog2(PATTERN_LEN + 1);
   localparam int AW = $clog2(PATTERN_LEN);
   localparam logic [LW-1:0] LastPos = LW'(PATTERN_LEN);
   localparam logic [PATTERN_LEN:0] RestartSet = (PATTERN_LEN + 1)'(1);

   state_type state_ff, state_in;
   class_state_type cls_ff, cls_in;

   logic [7:0]         mem [PATTERN_LEN];
   logic [7:0]         rd_data_ff;
   logic [AW-1:0]      rd_addr;

   logic [LW-1:0]      len_ff, len_in;
   logic [LW-1:0]      rb_pos_ff, rb_pos_in;
   logic               rb_valid_ff, rb_valid_in;
   logic               ovf_ff, ovf_in;
   logic [PATTERN_LEN:0] act_ff, act_in;
   logic [LW-1:0]      p_ff, p_in;
   logic [LW-1:0]      p_next;
   opcode_type         op_ff, op_in;
   logic [7:0]         sub_ff, sub_in;
   logic               act_carry_ff, act_carry_in;
   logic               nxt_carry_ff, nxt_carry_in;
   logic               cls_neg_ff, cls_neg_in;
   logic               cls_any_ff, cls_any_in;
   logic [7:0]         cls_lo_ff, cls_lo_in;
   logic               match_ff, match_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_matched_ff, rsp_matched_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   logic accept, req_ready, scan_en, rsp_load, mem_we;
   logic in_pat, eff, is_star, is_query, is_lb, closed, literal, nb;
   logic cls_end, cls_hit, any_add, cls_start;
   logic [7:0] t;

   assign accept = req.valid && req_ready;
   assign req.ready = req_ready;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.matched = rsp_matched_ff;
   assign rsp.pattern_overflow = rsp_ovf_ff;

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req.opcode == OP_SUBJECT || req.opcode == OP_END)) begin
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: state_in = ST_SCAN;
         ST_SCAN: begin
            if (p_ff == LastPos) begin
               state_in = (op_ff == OP_END) ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State-decoded controls.
   always_comb begin
      req_ready = 1'b0;
      scan_en = 1'b0;
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_PRIME: ;
         ST_SCAN: scan_en = 1'b1;
         ST_EMIT: rsp_load = !rsp_valid_ff || rsp.ready;
         default: ;
      endcase
   end

   // Scan position and its pattern byte; the registered read is addressed at p + 1.
   assign p_next = p_ff + LW'(1);
   assign rd_addr = (state_ff == ST_SCAN) ? p_next[AW-1:0] : '0;
   assign t = rd_data_ff;
   assign in_pat = p_ff < len_ff;
   assign is_star = (t == ChStar);
   assign is_query = (t == ChQuery);
   assign is_lb = (t == ChLBrack);
   // A bracket opens a class only if some close bracket follows it in the pattern.
   assign closed = rb_valid_ff && (rb_pos_ff > p_ff);
   assign literal = !is_star && !is_query && !(is_lb && closed);
   // Stars already passed extend the live set forward without consuming a byte.
   assign eff = act_ff[0] | act_carry_ff;
   assign cls_start = scan_en && in_pat && eff && is_lb && closed;

   // Class parser state. Nothing inside a closed class is ever live, so one parser suffices.
   always_comb begin
      cls_in = cls_ff;
      cls_neg_in = cls_neg_ff;
      cls_lo_in = cls_lo_ff;
      if (scan_en) begin
         unique case (cls_ff)
            CLS_OFF: begin
               if (cls_start) begin
                  cls_in = CLS_FIRST;
                  cls_neg_in = 1'b0;
               end
            end
            CLS_FIRST: begin
               if (t == ChBang || t == ChCaret) begin
                  cls_neg_in = 1'b1;
                  cls_in = CLS_ITEM;
               end else if (t == ChRBrack) begin
                  cls_in = CLS_OFF;
               end else begin
                  cls_lo_in = t;
                  cls_in = CLS_DASH;
               end
            end
            CLS_ITEM: begin
               if (t == ChRBrack) begin
                  cls_in = CLS_OFF;
               end else begin
                  cls_lo_in = t;
                  cls_in = CLS_DASH;
               end
            end
            CLS_DASH: begin
               if (t == ChDash) begin
                  cls_in = CLS_HI;
               end else if (t == ChRBrack) begin
                  cls_in = CLS_OFF;
               end else begin
                  cls_lo_in = t;
                  cls_in = CLS_DASH;
               end
            end
            CLS_HI: begin
               if (t != ChRBrack) begin
                  cls_in = CLS_ITEM;
               end else begin
                  cls_in = CLS_OFF;
               end
            end
            default: cls_in = CLS_OFF;
         endcase
      end
   end

   // Class parser outputs: the close of the class and the member hit at this position.
   always_comb begin
      cls_end = 1'b0;
      any_add = 1'b0;
      if (scan_en) begin
         unique case (cls_ff)
            CLS_OFF: ;
            CLS_FIRST: cls_end = (t == ChRBrack);
            CLS_ITEM: cls_end = (t == ChRBrack);
            CLS_DASH: begin
               if (t != ChDash) begin
                  any_add = (sub_ff == cls_lo_ff);
                  cls_end = (t == ChRBrack);
               end
            end
            CLS_HI: begin
               if (t != ChRBrack) begin
                  any_add = (sub_ff >= cls_lo_ff) && (sub_ff <= t);
               end else begin
                  // A dash right before the close bracket is a plain member.
                  any_add = (sub_ff == cls_lo_ff) || (sub_ff == ChDash);
                  cls_end = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   assign cls_any_in = (cls_ff == CLS_OFF) ? 1'b0 : (cls_any_ff | any_add);
   assign cls_hit = cls_neg_ff ^ (cls_any_ff | any_add);

   // New live bit for position p, rotated into the top of the active set.
   assign nb = nxt_carry_ff | (in_pat && eff && is_star);

   always_comb begin
      len_in = len_ff;
      rb_pos_in = rb_pos_ff;
      rb_valid_in = rb_valid_ff;
      ovf_in = ovf_ff;
      act_in = act_ff;
      p_in = p_ff;
      op_in = op_ff;
      sub_in = sub_ff;
      act_carry_in = act_carry_ff;
      nxt_carry_in = nxt_carry_ff;
      match_in = match_ff;
      mem_we = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_matched_in = rsp_matched_ff;
      rsp_ovf_in = rsp_ovf_ff;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         op_in = req.opcode;
         sub_in = req.data_byte;
         case (req.opcode)
            OP_CLEAR: begin
               len_in = '0;
               ovf_in = 1'b0;
               rb_valid_in = 1'b0;
               act_in = RestartSet;
            end
            OP_APPEND: begin
               if (len_ff < LastPos) begin
                  mem_we = 1'b1;
                  len_in = len_ff + LW'(1);
                  if (req.data_byte == ChRBrack) begin
                     rb_pos_in = len_ff;
                     rb_valid_in = 1'b1;
                  end
               end else begin
                  ovf_in = 1'b1;
               end
               act_in = RestartSet;
            end
            default: ;
         endcase
      end

      if (state_ff == ST_PRIME) begin
         p_in = '0;
         act_carry_in = 1'b0;
         nxt_carry_in = 1'b0;
      end

      if (scan_en) begin
         p_in = p_next;
         act_carry_in = in_pat && eff && is_star;
         nxt_carry_in = in_pat && ((eff && (is_query || (literal && sub_ff == t)))
                                   || (cls_end && cls_hit));
         act_in = {nb, act_ff[PATTERN_LEN:1]};
         if (p_ff == len_ff) begin
            match_in = eff;
         end
         if (p_ff == LastPos && op_ff == OP_END) begin
            act_in = RestartSet;
         end
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_matched_in = match_ff;
         rsp_ovf_in = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[len_ff[AW-1:0]] <= req.data_byte;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cls_ff <= CLS_OFF;
         len_ff <= '0;
         rb_valid_ff <= 1'b0;
         ovf_ff <= 1'b0;
         act_ff <= RestartSet;
         rsp_valid_ff <= 1'b0;
         act_carry_ff <= 1'b0;
         nxt_carry_ff <= 1'b0;
         p_ff <= '0;
      end else begin
         state_ff <= state_in;
         cls_ff <= cls_in;
         len_ff <= len_in;
         rb_valid_ff <= rb_valid_in;
         ovf_ff <= ovf_in;
         act_ff <= act_in;
         rsp_valid_ff <= rsp_valid_in;
         act_carry_ff <= act_carry_in;
         nxt_carry_ff <= nxt_carry_in;
         p_ff <= p_in;
      end
   end

   always_ff @(posedge clock) begin
      rb_pos_ff <= rb_pos_in;
      op_ff <= op_in;
      sub_ff <= sub_in;
      cls_neg_ff <= cls_neg_in;
      cls_any_ff <= cls_any_in;
      cls_lo_ff <= cls_lo_in;
      match_ff <= match_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("response raised outside the emit state");

   a_class_in_scan: assert property (@(posedge clock) disable iff (reset)
      (cls_ff != CLS_OFF) |-> (state_ff == ST_SCAN))
      else $error("class parser busy outside a scan");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LastPos)
      else $error("pattern length beyond capacity");

   a_restart_after_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (act_ff == RestartSet))
      else $error("active set not restarted after end of subject");

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && p_ff == LastPos) |=> (state_ff != ST_SCAN))
      else $error("scan ran past the last position");

endmodule

// ----- tb/sv/glob_wildcard_matcher_tb.sv -----
// Testbench for glob_wildcard_matcher: loads glob patterns, feeds subject names with random
// idle and stall bursts on both channels, and checks every verdict against a built-in matcher.
// Depends on gwm_pkg, the channel interfaces in gwm_if.sv and the block's RTL.
module glob_wildcard_matcher_tb;
   import gwm_pkg::*;

   localparam int PatLen = DefaultPatternLen;
   localparam int TotalWords = 1300;
   localparam int QuietWords = 200;

   typedef struct packed {
      opcode_type op;
      logic [7:0] data;
   } word_type;

   typedef struct {
      bit matched;
      bit overflow;
   } verdict_type;

   // Tracks the pattern and the set of live pattern positions, and holds the verdicts
   // that are still owed by the block.
   class verdict_board;
      bit [7:0] glob_bytes [PatLen];
      int glob_len;
      bit [PatLen:0] live;
      bit dropped;
      verdict_type expected_verdicts [$];
      int errors;

      function new();
         glob_len = 0;
         live = (PatLen + 1)'(1);
         dropped = 0;
         errors = 0;
      endfunction

      // A live star also makes the position after it live, which covers the empty run.
      function bit [PatLen:0] follow_stars(bit [PatLen:0] s);
         for (int p = 0; p < glob_len; p++)
            if (s[p] && glob_bytes[p] == ChStar) s[p + 1] = 1'b1;
         return s;
      endfunction

      // Returns 0 when the class opening at p has no closing bracket.
      function bit class_result(int p, bit [7:0] c, output int after, output bit hit);
         int q;
         bit negate;
         bit any;
         q = p + 1;
         negate = 0;
         any = 0;
         after = 0;
         hit = 0;
         if (q < glob_len && (glob_bytes[q] == ChBang || glob_bytes[q] == ChCaret)) begin
            negate = 1;
            q++;
         end
         while (q < glob_len && glob_bytes[q] != ChRBrack) begin
            if (q + 2 < glob_len && glob_bytes[q + 1] == ChDash &&
                glob_bytes[q + 2] != ChRBrack) begin
               if (c >= glob_bytes[q] && c <= glob_bytes[q + 2]) any = 1;
               q += 3;
            end else begin
               if (glob_bytes[q] == c) any = 1;
               q++;
            end
         end
         if (q >= glob_len) return 0;
         hit = negate ^ any;
         after = q + 1;
         return 1;
      endfunction

      function void advance(bit [7:0] c);
         bit [PatLen:0] cur;
         bit [PatLen:0] nxt;
         int after;
         bit hit;
         cur = follow_stars(live);
         nxt = '0;
         for (int p = 0; p < glob_len; p++) begin
            if (cur[p]) begin
               case (glob_bytes[p])
                  ChStar: nxt[p] = 1'b1;
                  ChQuery: nxt[p + 1] = 1'b1;
                  ChLBrack: begin
                     if (class_result(p, c, after, hit)) begin
                        if (hit) nxt[after] = 1'b1;
                     end else if (c == ChLBrack) begin
                        nxt[p + 1] = 1'b1;
                     end
                  end
                  default: if (c == glob_bytes[p]) nxt[p + 1] = 1'b1;
               endcase
            end
         end
         live = follow_stars(nxt);
      endfunction

      function void note_word(opcode_type op, bit [7:0] data);
         verdict_type v;
         case (op)
            OP_CLEAR: begin
               glob_len = 0;
               dropped = 0;
               live = (PatLen + 1)'(1);
            end
            OP_APPEND: begin
               if (glob_len < PatLen) begin
                  glob_bytes[glob_len] = data;
                  glob_len++;
               end else begin
                  dropped = 1;
               end
               live = (PatLen + 1)'(1);
            end
            OP_SUBJECT: advance(data);
            OP_END: begin
               live = follow_stars(live);
               v.matched = live[glob_len];
               v.overflow = dropped;
               expected_verdicts = {expected_verdicts, v};
               live = (PatLen + 1)'(1);
            end
         endcase
      endfunction

      function void check_verdict(bit matched, bit overflow);
         verdict_type v;
         if (expected_verdicts.size() == 0) begin
            errors++;
            $display("%0t: verdict with none expected: matched %0b pattern_overflow %0b",
                     $time, matched, overflow);
            return;
         end
         v = expected_verdicts.pop_front();
         if (matched != v.matched) begin
            errors++;
            $display("%0t: matched expected %0b actual %0b", $time, v.matched, matched);
         end
         if (overflow != v.overflow) begin
            errors++;
            $display("%0t: pattern_overflow expected %0b actual %0b",
                     $time, v.overflow, overflow);
         end
      endfunction

      function int pending();
         return expected_verdicts.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   gwm_req_if req_bus ();
   gwm_rsp_if rsp_bus ();

   glob_wildcard_matcher DUT (
      .clock(clock),
      .reset(reset),
      .req  (req_bus),
      .rsp  (rsp_bus)
   );

   verdict_board board = new();
   int words_sent;
   bit quiet;
   int stall_left = 0;

   // Empty pattern and empty name, [!], the empty class [], an unsigned high range,
   // and an unclosed bracket taken literally.
   word_type directed [] = '{
      '{OP_END, 8'h00},
      '{OP_SUBJECT, 8'h00}, '{OP_END, 8'hFF},
      '{OP_APPEND, ChLBrack}, '{OP_APPEND, ChBang}, '{OP_APPEND, ChRBrack},
      '{OP_SUBJECT, 8'hFF}, '{OP_END, 8'h00},
      '{OP_CLEAR, 8'hFF}, '{OP_APPEND, ChLBrack}, '{OP_APPEND, ChRBrack},
      '{OP_SUBJECT, ChRBrack}, '{OP_END, 8'h00},
      '{OP_CLEAR, 8'h00}, '{OP_APPEND, ChLBrack}, '{OP_APPEND, 8'h80}, '{OP_APPEND, ChDash},
      '{OP_APPEND, 8'hFF}, '{OP_APPEND, ChRBrack}, '{OP_APPEND, ChStar},
      '{OP_SUBJECT, 8'hC0}, '{OP_END, 8'h00},
      '{OP_CLEAR, 8'h00}, '{OP_APPEND, ChLBrack}, '{OP_APPEND, ChQuery},
      '{OP_SUBJECT, ChLBrack}, '{OP_SUBJECT, 8'h7F}, '{OP_END, 8'h00}
   };

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #6_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Results are checked before the word of the same edge is noted, so a verdict can
   // never pair with an end of subject accepted at that very edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready)
            board.check_verdict(rsp_bus.matched, rsp_bus.pattern_overflow);
         if (req_bus.valid && req_bus.ready)
            board.note_word(req_bus.opcode, req_bus.data_byte);
      end
   end

   // Every third block of a hundred words runs without idling on either side.
   function automatic bit calm();
      return quiet || (words_sent / 100) % 3 == 2;
   endfunction

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (!calm() && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 15);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   task automatic send_word(opcode_type op, bit [7:0] data);
      if (!calm() && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.opcode <= op;
      req_bus.data_byte <= data;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      words_sent++;
      quiet = words_sent >= TotalWords - QuietWords;
   endtask

   function automatic void add_byte(ref bit [7:0] dst[$], input bit [7:0] b);
      dst = {dst, b};
   endfunction

   function automatic bit [7:0] rand_meta();
      case ($urandom_range(0, 6))
         0: return ChStar;
         1: return ChQuery;
         2: return ChLBrack;
         3: return ChRBrack;
         4: return ChBang;
         5: return ChCaret;
         default: return ChDash;
      endcase
   endfunction

   // Mostly a few letters so that names hit the pattern, with the byte extremes mixed in.
   function automatic bit [7:0] rand_name_byte();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return 8'h61 + 8'($urandom_range(0, 2));
         5: return 8'h80;
         6: return 8'hFF;
         7: return 8'h00;
         8: return rand_meta();
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic void build_glob(ref bit [7:0] glob[$], input int target);
      while (glob.size() < target) begin
         case ($urandom_range(0, 9))
            0, 1: add_byte(glob, ChStar);
            2: add_byte(glob, ChQuery);
            3, 4: begin
               add_byte(glob, ChLBrack);
               if ($urandom_range(0, 2) == 0)
                  add_byte(glob, $urandom_range(0, 1) ? ChBang : ChCaret);
               repeat ($urandom_range(0, 3)) begin
                  add_byte(glob, rand_name_byte());
                  if ($urandom_range(0, 1)) begin
                     add_byte(glob, ChDash);
                     add_byte(glob, rand_name_byte());
                  end
               end
               if ($urandom_range(0, 7) != 0) add_byte(glob, ChRBrack);
            end
            5: add_byte(glob, rand_meta());
            default: add_byte(glob, rand_name_byte());
         endcase
      end
   endfunction

   // Walks the pattern to build a name that is likely to match, then sometimes spoils it.
   function automatic void build_name(bit [7:0] glob[$], ref bit [7:0] name[$]);
      int i;
      int j;
      if ($urandom_range(0, 2) == 0) begin
         repeat ($urandom_range(0, 8)) add_byte(name, rand_name_byte());
         return;
      end
      i = 0;
      while (i < glob.size()) begin
         if (glob[i] == ChStar) begin
            repeat ($urandom_range(0, 3)) add_byte(name, rand_name_byte());
            i++;
         end else if (glob[i] == ChQuery) begin
            add_byte(name, rand_name_byte());
            i++;
         end else if (glob[i] == ChLBrack) begin
            j = i + 1;
            while (j < glob.size() && glob[j] != ChRBrack) j++;
            if (j >= glob.size()) begin
               add_byte(name, ChLBrack);
               i++;
            end else begin
               add_byte(name,
                        j > i + 1 ? glob[$urandom_range(i + 1, j - 1)] : rand_name_byte());
               i = j + 1;
            end
         end else begin
            add_byte(name, glob[i]);
            i++;
         end
      end
      if (name.size() > 0 && $urandom_range(0, 3) == 0)
         name[$urandom_range(0, name.size() - 1)] = rand_name_byte();
      if ($urandom_range(0, 5) == 0) add_byte(name, rand_name_byte());
   endfunction

   task automatic run_episode();
      bit [7:0] glob[$];
      bit [7:0] name[$];
      int target;
      if ($urandom_range(0, 11) == 0) begin
         repeat ($urandom_range(1, 5))
            send_word(opcode_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
         return;
      end
      // A rare long pattern can run past the store and set the overflow flag.
      target = ($urandom_range(0, 24) == 0) ? $urandom_range(58, 72) : $urandom_range(0, 10);
      build_glob(glob, target);
      if ($urandom_range(0, 3) != 0) send_word(OP_CLEAR, 8'($urandom_range(0, 255)));
      foreach (glob[i]) send_word(OP_APPEND, glob[i]);
      repeat ($urandom_range(1, 4)) begin
         name.delete();
         build_name(glob, name);
         foreach (name[i]) begin
            send_word(OP_SUBJECT, name[i]);
            // An append in the middle of a name abandons it.
            if ($urandom_range(0, 60) == 0) send_word(OP_APPEND, rand_name_byte());
         end
         send_word(OP_END, 8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.opcode = OP_CLEAR;
      req_bus.data_byte = 8'h00;
      words_sent = 0;
      quiet = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send_word(directed[i].op, directed[i].data);
      while (words_sent < TotalWords) run_episode();
      req_bus.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (2 * PatLen + 16) @(posedge clock);
      if (board.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
